// ----- design/mbd_pkg.sv -----
// Package: widths, decode codes, request command and result types, protection table.
package mbd_pkg;

   localparam int DATA_W           = 8;
   localparam int ADDR_W           = 16;
   localparam int ROM_ADDR_W       = 18;
   localparam int BANK_W           = 3;
   localparam int LAYER_W          = 4;
   localparam int SCROLL_W         = 16;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;

   localparam int WORK_RAM_DEPTH   = 4096;
   localparam int CHAR_RAM_DEPTH   = 2048;
   localparam int SPRITE_RAM_DEPTH = 4096;
   localparam int WORK_IDX_W       = $clog2(WORK_RAM_DEPTH);
   localparam int CHAR_IDX_W       = $clog2(CHAR_RAM_DEPTH);
   localparam int SPR_IDX_W        = $clog2(SPRITE_RAM_DEPTH);
   localparam int MIRROR_IDX_W     = 7;

   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic CSR_DIP_A = 1'b0;
   localparam logic CSR_DIP_B = 1'b1;
   localparam logic [DATA_W-1:0] DIP_A_RESET = 8'hEF;
   localparam logic [DATA_W-1:0] DIP_B_RESET = 8'hFF;

   localparam logic [3:0] PAGE_C = 4'hC;
   localparam logic [3:0] PAGE_D = 4'hD;
   localparam logic [3:0] PAGE_E = 4'hE;
   localparam logic [3:0] PAGE_F = 4'hF;

   localparam logic [ADDR_W-1:0] ADDR_SYS         = 16'hC000;
   localparam logic [ADDR_W-1:0] ADDR_P1          = 16'hC001;
   localparam logic [ADDR_W-1:0] ADDR_P2          = 16'hC002;
   localparam logic [ADDR_W-1:0] ADDR_DIP_A       = 16'hC003;
   localparam logic [ADDR_W-1:0] ADDR_DIP_B       = 16'hC004;
   localparam logic [ADDR_W-1:0] ADDR_PROT_RD     = 16'hC007;
   localparam logic [ADDR_W-1:0] ADDR_LATCH       = 16'hC800;
   localparam logic [ADDR_W-1:0] ADDR_BANK_LAYER  = 16'hC804;
   localparam logic [ADDR_W-1:0] ADDR_PALBANK     = 16'hC805;
   localparam logic [ADDR_W-1:0] ADDR_BANK        = 16'hC806;
   localparam logic [ADDR_W-1:0] ADDR_PROT_WR     = 16'hC807;
   localparam logic [ADDR_W-1:0] ADDR_MIRROR_LO   = 16'hCC00;
   localparam logic [ADDR_W-1:0] ADDR_MIRROR_HI   = 16'hCC80;
   localparam logic [ADDR_W-1:0] ADDR_CHAR_END    = 16'hD800;
   localparam logic [ADDR_W-1:0] ADDR_SCROLLX_LO  = 16'hD800;
   localparam logic [ADDR_W-1:0] ADDR_SCROLLX_HI  = 16'hD801;
   localparam logic [ADDR_W-1:0] ADDR_SCROLLY     = 16'hD802;
   localparam logic [ADDR_W-1:0] ADDR_BGSCROLL_LO = 16'hD803;
   localparam logic [ADDR_W-1:0] ADDR_BGSCROLL_HI = 16'hD804;
   localparam logic [ADDR_W-1:0] ADDR_LAYER_LO    = 16'hD806;

   localparam logic [DATA_W-1:0] VBLANK_OFF_MASK = 8'h08;
   localparam int BANK_SHIFT = 14;
   localparam logic [ROM_ADDR_W-1:0] ROM_BANK_BASE = 18'h10000;

   typedef enum logic [4:0] {
      CMD_UNMAPPED,
      CMD_ROM_FIX,
      CMD_ROM_BANK,
      CMD_PORT,
      CMD_PROT,
      CMD_CHAR_RD,
      CMD_WORK_RD,
      CMD_SPR_RD,
      CMD_WR_LATCH,
      CMD_WR_BANK_LAYER,
      CMD_WR_PALBANK,
      CMD_WR_BANK,
      CMD_WR_PROT,
      CMD_WR_CHAR,
      CMD_WR_SCROLLX_LO,
      CMD_WR_SCROLLX_HI,
      CMD_WR_SCROLLY,
      CMD_WR_BGSCROLL_LO,
      CMD_WR_BGSCROLL_HI,
      CMD_WR_LAYER_LO,
      CMD_WR_WORK,
      CMD_WR_SPR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [ADDR_W-1:0]       addr;
      logic [SPR_IDX_W-1:0]    idx;
      logic [DATA_W-1:0]       data;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] dip_a;
      logic [DATA_W-1:0] dip_b;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0]     rdata;
      logic                  rom_read;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic                  unmapped;
      logic [DATA_W-1:0]     sound_latch;
      logic [LAYER_W-1:0]    layer_enable;
      logic [DATA_W-1:0]     palette_bank;
      logic [SCROLL_W-1:0]   scroll_x;
      logic [DATA_W-1:0]     scroll_y;
      logic [SCROLL_W-1:0]   bg2_scroll;
      logic [BANK_W-1:0]     rom_bank;
   } result_type;

   localparam int PROT_ENTRIES = 32;

   localparam logic [DATA_W-1:0] PROT_KEY [PROT_ENTRIES] = '{
      8'h24, 8'h60, 8'h01, 8'h55, 8'h56, 8'h2a, 8'ha8, 8'h22,
      8'h3b, 8'h1e, 8'he9, 8'h7d, 8'h43, 8'h37, 8'h4c, 8'h5f,
      8'h3f, 8'h3e, 8'hfb, 8'h1d, 8'h27, 8'h26, 8'h58, 8'h32,
      8'h1a, 8'hbc, 8'h30, 8'h64, 8'h11, 8'h33, 8'h09, 8'h25
   };

   localparam logic [DATA_W-1:0] PROT_VAL [PROT_ENTRIES] = '{
      8'h1d, 8'hf7, 8'hac, 8'h50, 8'he2, 8'h58, 8'h13, 8'h3e,
      8'h5a, 8'h1b, 8'h41, 8'hd5, 8'h54, 8'h6f, 8'h59, 8'h56,
      8'h2f, 8'h3d, 8'h36, 8'h3b, 8'hae, 8'h39, 8'h3c, 8'h51,
      8'ha8, 8'h33, 8'h4a, 8'h12, 8'h40, 8'h35, 8'h17, 8'h04
   };

   function automatic logic [DATA_W-1:0] prot_lookup(input logic [DATA_W-1:0] key);
      logic [DATA_W-1:0] v;
      v = '0;
      for (int i = PROT_ENTRIES - 1; i >= 0; i--) begin
         if (PROT_KEY[i] == key) begin
            v = PROT_VAL[i];
         end
      end
      return v;
   endfunction

endpackage

// ----- design/mbd_if.sv -----
// Interfaces: request and response channels.
interface mbd_req_if;
   import mbd_pkg::*;
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [ADDR_W-1:0]   addr;
   logic [DATA_W-1:0]   wdata;
   logic                in_vblank;
   logic [DATA_W-1:0]   system_port;
   logic [DATA_W-1:0]   p1_port;
   logic [DATA_W-1:0]   p2_port;

   modport source (output valid, req_type, addr, wdata, in_vblank, system_port, p1_port,
                   p2_port, input ready);
   modport sink (input valid, req_type, addr, wdata, in_vblank, system_port, p1_port,
                 p2_port, output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DATA_W-1:0]     rdata;
   logic                  rom_read;
   logic [ROM_ADDR_W-1:0] rom_addr;
   logic                  unmapped;
   logic [DATA_W-1:0]     sound_latch;
   logic [LAYER_W-1:0]    layer_enable;
   logic [DATA_W-1:0]     palette_bank;
   logic [SCROLL_W-1:0]   scroll_x;
   logic [DATA_W-1:0]     scroll_y;
   logic [SCROLL_W-1:0]   bg2_scroll;
   logic [BANK_W-1:0]     rom_bank;

   modport source (output valid, rdata, rom_read, rom_addr, unmapped, sound_latch,
                   layer_enable, palette_bank, scroll_x, scroll_y, bg2_scroll, rom_bank,
                   input ready);
   modport sink (input valid, rdata, rom_read, rom_addr, unmapped, sound_latch,
                 layer_enable, palette_bank, scroll_x, scroll_y, bg2_scroll, rom_bank,
                 output ready);
endinterface

// ----- design/mbd_front.sv -----
// Front end: accept bus requests, decode them against the memory map, register the command.
module mbd_front (
   input  logic             clock,
   input  logic             reset,
   mbd_req_if.sink          req_bus,
   input  mbd_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             push,
   output mbd_pkg::cmd_type push_cmd
);
   import mbd_pkg::*;

   logic              valid_ff, valid_in;
   cmd_type           cmd_ff, cmd_in;
   logic              accept;
   logic [ADDR_W-1:0] a;
   logic [3:0]        page;

   assign push          = valid_ff && !q_full;
   assign req_bus.ready = !valid_ff || !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_cmd      = cmd_ff;
   assign a             = req_bus.addr;
   assign page          = a[ADDR_W-1:ADDR_W-4];

   always_comb begin
      cmd_in.kind = CMD_UNMAPPED;
      cmd_in.addr = a;
      cmd_in.idx  = a[SPR_IDX_W-1:0];
      cmd_in.data = req_bus.wdata;
      if (req_bus.req_type == REQ_WRITE) begin
         case (page)
            PAGE_C: begin
               if (a >= ADDR_MIRROR_LO && a < ADDR_MIRROR_HI) begin
                  cmd_in.kind = CMD_WR_SPR;
                  cmd_in.idx  = SPR_IDX_W'(a[MIRROR_IDX_W-1:0]);
               end else begin
                  case (a)
                     ADDR_LATCH:      cmd_in.kind = CMD_WR_LATCH;
                     ADDR_BANK_LAYER: cmd_in.kind = CMD_WR_BANK_LAYER;
                     ADDR_PALBANK:    cmd_in.kind = CMD_WR_PALBANK;
                     ADDR_BANK:       cmd_in.kind = CMD_WR_BANK;
                     ADDR_PROT_WR:    cmd_in.kind = CMD_WR_PROT;
                     default:         cmd_in.kind = CMD_UNMAPPED;
                  endcase
               end
            end
            PAGE_D: begin
               if (a < ADDR_CHAR_END) begin
                  cmd_in.kind = CMD_WR_CHAR;
                  cmd_in.idx  = SPR_IDX_W'(a[CHAR_IDX_W-1:0]);
               end else begin
                  case (a)
                     ADDR_SCROLLX_LO:  cmd_in.kind = CMD_WR_SCROLLX_LO;
                     ADDR_SCROLLX_HI:  cmd_in.kind = CMD_WR_SCROLLX_HI;
                     ADDR_SCROLLY:     cmd_in.kind = CMD_WR_SCROLLY;
                     ADDR_BGSCROLL_LO: cmd_in.kind = CMD_WR_BGSCROLL_LO;
                     ADDR_BGSCROLL_HI: cmd_in.kind = CMD_WR_BGSCROLL_HI;
                     ADDR_LAYER_LO:    cmd_in.kind = CMD_WR_LAYER_LO;
                     default:          cmd_in.kind = CMD_UNMAPPED;
                  endcase
               end
            end
            PAGE_E:  cmd_in.kind = CMD_WR_WORK;
            PAGE_F:  cmd_in.kind = CMD_WR_SPR;
            default: cmd_in.kind = CMD_UNMAPPED;
         endcase
      end else if (!a[ADDR_W-1]) begin
         cmd_in.kind = CMD_ROM_FIX;
      end else if (!a[ADDR_W-2]) begin
         cmd_in.kind = CMD_ROM_BANK;
      end else begin
         case (page)
            PAGE_C: begin
               case (a)
                  ADDR_SYS: begin
                     cmd_in.kind = CMD_PORT;
                     cmd_in.data = req_bus.in_vblank ? req_bus.system_port
                                                     : (req_bus.system_port | VBLANK_OFF_MASK);
                  end
                  ADDR_P1: begin
                     cmd_in.kind = CMD_PORT;
                     cmd_in.data = req_bus.p1_port;
                  end
                  ADDR_P2: begin
                     cmd_in.kind = CMD_PORT;
                     cmd_in.data = req_bus.p2_port;
                  end
                  ADDR_DIP_A: begin
                     cmd_in.kind = CMD_PORT;
                     cmd_in.data = cfg.dip_a;
                  end
                  ADDR_DIP_B: begin
                     cmd_in.kind = CMD_PORT;
                     cmd_in.data = cfg.dip_b;
                  end
                  ADDR_PROT_RD: cmd_in.kind = CMD_PROT;
                  default:      cmd_in.kind = CMD_UNMAPPED;
               endcase
            end
            PAGE_D: begin
               if (a < ADDR_CHAR_END) begin
                  cmd_in.kind = CMD_CHAR_RD;
                  cmd_in.idx  = SPR_IDX_W'(a[CHAR_IDX_W-1:0]);
               end
            end
            PAGE_E:  cmd_in.kind = CMD_WORK_RD;
            default: cmd_in.kind = CMD_SPR_RD;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ----- design/mbd_queue.sv -----
// Command queue between the decode front end and the execute back end.
module mbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output mbd_pkg::cmd_type pop_cmd,
   output logic             full,
   output logic             empty
);
   import mbd_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] n;
      n = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/mbd_back.sv -----
// Back end: RAMs and I/O registers; execute commands and register the response.
module mbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  mbd_pkg::cmd_type q_cmd,
   output logic             pop,
   mbd_rsp_if.source        rsp_bus
);
   import mbd_pkg::*;

   logic [DATA_W-1:0] work_ram   [WORK_RAM_DEPTH];
   logic [DATA_W-1:0] char_ram   [CHAR_RAM_DEPTH];
   logic [DATA_W-1:0] sprite_ram [SPRITE_RAM_DEPTH];

   logic [DATA_W-1:0] work_rd_ff, char_rd_ff, spr_rd_ff;

   logic       exec_valid_ff, exec_valid_in;
   cmd_type    exec_cmd_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, res_in;
   logic       move;

   logic [DATA_W-1:0]   latch_ff, latch_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   logic [LAYER_W-1:0]  enable_ff, enable_in;
   logic [DATA_W-1:0]   palbank_ff, palbank_in;
   logic [DATA_W-1:0]   protect_ff, protect_in;
   logic [SCROLL_W-1:0] scrollx_ff, scrollx_in;
   logic [DATA_W-1:0]   scrolly_ff, scrolly_in;
   logic [SCROLL_W-1:0] bgscroll_ff, bgscroll_in;

   assign move = exec_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign pop  = !q_empty && (!exec_valid_ff || move);

   // RAM ports: write and registered read at pop
   always_ff @(posedge clock) begin
      if (pop) begin
         if (q_cmd.kind == CMD_WR_WORK) begin
            work_ram[q_cmd.idx[WORK_IDX_W-1:0]] <= q_cmd.data;
         end
         work_rd_ff <= work_ram[q_cmd.idx[WORK_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (q_cmd.kind == CMD_WR_CHAR) begin
            char_ram[q_cmd.idx[CHAR_IDX_W-1:0]] <= q_cmd.data;
         end
         char_rd_ff <= char_ram[q_cmd.idx[CHAR_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (q_cmd.kind == CMD_WR_SPR) begin
            sprite_ram[q_cmd.idx] <= q_cmd.data;
         end
         spr_rd_ff <= sprite_ram[q_cmd.idx];
      end
   end

   always_comb begin
      latch_in    = latch_ff;
      bank_in     = bank_ff;
      enable_in   = enable_ff;
      palbank_in  = palbank_ff;
      protect_in  = protect_ff;
      scrollx_in  = scrollx_ff;
      scrolly_in  = scrolly_ff;
      bgscroll_in = bgscroll_ff;
      if (pop) begin
         case (q_cmd.kind)
            CMD_WR_LATCH: latch_in = q_cmd.data;
            CMD_WR_BANK_LAYER: begin
               bank_in      = q_cmd.data[4:2];
               enable_in[3] = q_cmd.data[7];
            end
            CMD_WR_PALBANK:     palbank_in = q_cmd.data;
            CMD_WR_BANK:        bank_in = q_cmd.data[BANK_W-1:0];
            CMD_WR_PROT:        protect_in = q_cmd.data;
            CMD_WR_SCROLLX_LO:  scrollx_in[7:0] = q_cmd.data;
            CMD_WR_SCROLLX_HI:  scrollx_in[15:8] = q_cmd.data;
            CMD_WR_SCROLLY:     scrolly_in = q_cmd.data;
            CMD_WR_BGSCROLL_LO: bgscroll_in[7:0] = q_cmd.data;
            CMD_WR_BGSCROLL_HI: bgscroll_in[15:8] = q_cmd.data;
            CMD_WR_LAYER_LO:    enable_in[2:0] = q_cmd.data[6:4];
            default: ;
         endcase
      end
   end

   always_comb begin
      res_in.rdata        = '0;
      res_in.rom_read     = 1'b0;
      res_in.rom_addr     = '0;
      res_in.unmapped     = 1'b0;
      res_in.sound_latch  = latch_ff;
      res_in.layer_enable = enable_ff;
      res_in.palette_bank = palbank_ff;
      res_in.scroll_x     = scrollx_ff;
      res_in.scroll_y     = scrolly_ff;
      res_in.bg2_scroll   = bgscroll_ff;
      res_in.rom_bank     = bank_ff;
      case (exec_cmd_ff.kind)
         CMD_ROM_FIX: begin
            res_in.rom_read = 1'b1;
            res_in.rom_addr = ROM_ADDR_W'(exec_cmd_ff.addr[ADDR_W-2:0]);
         end
         CMD_ROM_BANK: begin
            res_in.rom_read = 1'b1;
            res_in.rom_addr = ROM_BANK_BASE + (ROM_ADDR_W'(bank_ff) << BANK_SHIFT)
                              + ROM_ADDR_W'(exec_cmd_ff.addr[BANK_SHIFT-1:0]);
         end
         CMD_PORT:     res_in.rdata = exec_cmd_ff.data;
         CMD_PROT:     res_in.rdata = prot_lookup(protect_ff);
         CMD_CHAR_RD:  res_in.rdata = char_rd_ff;
         CMD_WORK_RD:  res_in.rdata = work_rd_ff;
         CMD_SPR_RD:   res_in.rdata = spr_rd_ff;
         CMD_UNMAPPED: res_in.unmapped = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (pop) begin
         exec_valid_in = 1'b1;
      end else if (move) begin
         exec_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         latch_ff      <= '0;
         bank_ff       <= '0;
         enable_ff     <= '0;
         palbank_ff    <= '0;
         protect_ff    <= '0;
         scrollx_ff    <= '0;
         scrolly_ff    <= '0;
         bgscroll_ff   <= '0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         out_valid_ff  <= out_valid_in;
         latch_ff      <= latch_in;
         bank_ff       <= bank_in;
         enable_ff     <= enable_in;
         palbank_ff    <= palbank_in;
         protect_ff    <= protect_in;
         scrollx_ff    <= scrollx_in;
         scrolly_ff    <= scrolly_in;
         bgscroll_ff   <= bgscroll_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         exec_cmd_ff <= q_cmd;
      end
      if (move) begin
         out_ff <= res_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.rdata        = out_ff.rdata;
   assign rsp_bus.rom_read     = out_ff.rom_read;
   assign rsp_bus.rom_addr     = out_ff.rom_addr;
   assign rsp_bus.unmapped     = out_ff.unmapped;
   assign rsp_bus.sound_latch  = out_ff.sound_latch;
   assign rsp_bus.layer_enable = out_ff.layer_enable;
   assign rsp_bus.palette_bank = out_ff.palette_bank;
   assign rsp_bus.scroll_x     = out_ff.scroll_x;
   assign rsp_bus.scroll_y     = out_ff.scroll_y;
   assign rsp_bus.bg2_scroll   = out_ff.bg2_scroll;
   assign rsp_bus.rom_bank     = out_ff.rom_bank;

endmodule

// ----- design/main_bus_decoder_with_io_registers.sv -----
// Top level: main bus decoder with RAMs, I/O registers and DIP switch CSRs.
//
//   port group   direction  handshake            carries
//   req_bus      in         valid / ready        one bus request (read or write)
//   rsp_bus      out        valid / ready        one response per request
//   apb (p*)     in         psel/penable/pready  dip_a at 0x0, dip_b at 0x4
//
// Sustains one request per cycle while the response side keeps taking responses; a request
// passes through the decode register, queue, RAM read in execute and response register.
// Reset clears control state and I/O registers, sets dip_a to 0xEF and dip_b to 0xFF;
// RAM contents are not cleared. The two-entry queue lets a stalled response side
// hold off the back end while the front end keeps taking requests until it fills.
module main_bus_decoder_with_io_registers (
   input  logic                            clock,
   input  logic                            reset,
   mbd_req_if.sink                         req_bus,
   mbd_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mbd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mbd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import mbd_pkg::*;

   logic [DATA_W-1:0] dip_a_ff, dip_a_in;
   logic [DATA_W-1:0] dip_b_ff, dip_b_in;
   logic              csr_wr;
   cfg_type           cfg;
   logic              push, pop, q_full, q_empty;
   cmd_type           push_cmd, pop_cmd;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      dip_a_in = dip_a_ff;
      dip_b_in = dip_b_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_DIP_A: dip_a_in = pwdata[DATA_W-1:0];
            CSR_DIP_B: dip_b_in = pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_DIP_A: prdata = CSR_DATA_W'(dip_a_ff);
         CSR_DIP_B: prdata = CSR_DATA_W'(dip_b_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= DIP_A_RESET;
         dip_b_ff <= DIP_B_RESET;
      end else begin
         dip_a_ff <= dip_a_in;
         dip_b_ff <= dip_b_in;
      end
   end

   assign cfg.dip_a = dip_a_ff;
   assign cfg.dip_b = dip_b_ff;

   mbd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   mbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   mbd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- design/mbd_checker.sv -----
// Checker: response channel properties seen at the top level ports, and its bind.
module mbd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mbd_pkg::DATA_W-1:0]          rdata,
   input logic                                rom_read,
   input logic [mbd_pkg::ROM_ADDR_W-1:0]      rom_addr,
   input logic                                unmapped
);
   import mbd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rdata) && $stable(rom_addr))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rom_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rom_read |-> !unmapped && rdata == '0)
      else $error("ROM fetch with data or unmapped flag");

   a_unmapped_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && unmapped |-> rdata == '0 && !rom_read)
      else $error("unmapped access returned data");

   a_rom_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rom_read |-> rom_addr == '0)
      else $error("ROM address on a non-ROM access");

endmodule

bind main_bus_decoder_with_io_registers mbd_checker u_mbd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rdata     (rsp_bus.rdata),
   .rom_read  (rsp_bus.rom_read),
   .rom_addr  (rsp_bus.rom_addr),
   .unmapped  (rsp_bus.unmapped)
);

// ----- test/tb_main_bus_decoder_with_io_registers.sv -----
`timescale 1ns / 100ps
// Testbench: directed and random bus requests checked against a predictor of the decoder.
module tb_main_bus_decoder_with_io_registers;
   import mbd_pkg::*;

   localparam int CLK_HALF        = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int MAX_GAP         = 17;
   localparam int RSP_HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES   = 6;
   localparam int NUM_REGIONS     = 3;
   localparam int RUN_LIMIT_NS    = 5_000_000;

   typedef enum int {RGN_CHAR, RGN_WORK, RGN_SPRITE} ram_region_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic              in_vblank;
      logic [DATA_W-1:0] system_port;
      logic [DATA_W-1:0] p1_port;
      logic [DATA_W-1:0] p2_port;
   } bus_access_type;

   localparam logic [ADDR_W-1:0] PORT_READ_ADDRS [6] = '{
      ADDR_SYS, ADDR_P1, ADDR_P2, ADDR_DIP_A, ADDR_DIP_B, ADDR_PROT_RD
   };
   localparam logic [ADDR_W-1:0] IO_WRITE_ADDRS [11] = '{
      ADDR_LATCH, ADDR_BANK_LAYER, ADDR_PALBANK, ADDR_BANK, ADDR_PROT_WR,
      ADDR_SCROLLX_LO, ADDR_SCROLLX_HI, ADDR_SCROLLY, ADDR_BGSCROLL_LO,
      ADDR_BGSCROLL_HI, ADDR_LAYER_LO
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mbd_req_if req_bus ();
   mbd_rsp_if rsp_bus ();

   main_bus_decoder_with_io_registers u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [DATA_W-1:0]   dip_a_q, dip_b_q, latch_q, palbank_q, protect_q, scrolly_q;
   logic [BANK_W-1:0]   bank_q;
   logic [LAYER_W-1:0]  layer_q;
   logic [SCROLL_W-1:0] scrollx_q, bgscroll_q;
   logic [DATA_W-1:0]   ram_mem [NUM_REGIONS][SPRITE_RAM_DEPTH];
   bit                  ram_seen [NUM_REGIONS][SPRITE_RAM_DEPTH];
   int                  ram_written [NUM_REGIONS][$];

   result_type expected_results [$];
   int         error_count = 0;
   bit         req_idle;
   bit         rsp_hold;
   event       hold_rsp_ev;

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   initial begin
      #RUN_LIMIT_NS;
      $display("main_bus_decoder_with_io_registers verification failed");
      $finish;
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void store_ram(ram_region_type rgn, int idx, logic [DATA_W-1:0] d);
      ram_mem[rgn][idx] = d;
      if (!ram_seen[rgn][idx]) begin
         ram_seen[rgn][idx] = 1'b1;
         ram_written[rgn].push_back(idx);
      end
   endfunction

   function automatic logic [ADDR_W-1:0] ram_address(ram_region_type rgn, int idx);
      case (rgn)
         RGN_CHAR: return {PAGE_D, 1'b0, CHAR_IDX_W'(idx)};
         RGN_WORK: return {PAGE_E, WORK_IDX_W'(idx)};
         default:  return {PAGE_F, SPR_IDX_W'(idx)};
      endcase
   endfunction

   function automatic bus_access_type make_access(logic kind, logic [ADDR_W-1:0] a,
                                                  logic [DATA_W-1:0] d);
      bus_access_type acc;
      acc.req_type    = kind;
      acc.addr        = a;
      acc.wdata       = d;
      acc.in_vblank   = 1'($urandom);
      acc.system_port = DATA_W'($urandom);
      acc.p1_port     = DATA_W'($urandom);
      acc.p2_port     = DATA_W'($urandom);
      return acc;
   endfunction

   function automatic result_type predict_bus_access(bus_access_type acc);
      result_type  r;
      logic [3:0]  page;
      bit          hit;
      bit          found;
      r     = '0;
      page  = acc.addr[ADDR_W-1 -: 4];
      hit   = 1'b1;
      found = 1'b0;
      if (acc.req_type == REQ_WRITE) begin
         if (page == PAGE_C) begin
            if (acc.addr >= ADDR_MIRROR_LO && acc.addr < ADDR_MIRROR_HI) begin
               store_ram(RGN_SPRITE, int'(acc.addr[MIRROR_IDX_W-1:0]), acc.wdata);
            end else begin
               case (acc.addr)
                  ADDR_LATCH: latch_q = acc.wdata;
                  ADDR_BANK_LAYER: begin
                     bank_q     = acc.wdata[4:2];
                     layer_q[3] = acc.wdata[7];
                  end
                  ADDR_PALBANK: palbank_q = acc.wdata;
                  ADDR_BANK:    bank_q = acc.wdata[BANK_W-1:0];
                  ADDR_PROT_WR: protect_q = acc.wdata;
                  default:      hit = 1'b0;
               endcase
            end
         end else if (page == PAGE_D) begin
            if (acc.addr < ADDR_CHAR_END) begin
               store_ram(RGN_CHAR, int'(acc.addr[CHAR_IDX_W-1:0]), acc.wdata);
            end else begin
               case (acc.addr)
                  ADDR_SCROLLX_LO:  scrollx_q[7:0] = acc.wdata;
                  ADDR_SCROLLX_HI:  scrollx_q[15:8] = acc.wdata;
                  ADDR_SCROLLY:     scrolly_q = acc.wdata;
                  ADDR_BGSCROLL_LO: bgscroll_q[7:0] = acc.wdata;
                  ADDR_BGSCROLL_HI: bgscroll_q[15:8] = acc.wdata;
                  ADDR_LAYER_LO:    layer_q[2:0] = acc.wdata[6:4];
                  default:          hit = 1'b0;
               endcase
            end
         end else if (page == PAGE_E) begin
            store_ram(RGN_WORK, int'(acc.addr[WORK_IDX_W-1:0]), acc.wdata);
         end else if (page == PAGE_F) begin
            store_ram(RGN_SPRITE, int'(acc.addr[SPR_IDX_W-1:0]), acc.wdata);
         end else begin
            hit = 1'b0;
         end
      end else if (!acc.addr[ADDR_W-1]) begin
         r.rom_read = 1'b1;
         r.rom_addr = ROM_ADDR_W'(acc.addr);
      end else if (acc.addr < ADDR_SYS) begin
         r.rom_read = 1'b1;
         r.rom_addr = ROM_BANK_BASE + (ROM_ADDR_W'(bank_q) << BANK_SHIFT)
                      + ROM_ADDR_W'(acc.addr[BANK_SHIFT-1:0]);
      end else if (page == PAGE_C) begin
         case (acc.addr)
            ADDR_SYS:   r.rdata = acc.system_port | (acc.in_vblank ? '0 : VBLANK_OFF_MASK);
            ADDR_P1:    r.rdata = acc.p1_port;
            ADDR_P2:    r.rdata = acc.p2_port;
            ADDR_DIP_A: r.rdata = dip_a_q;
            ADDR_DIP_B: r.rdata = dip_b_q;
            ADDR_PROT_RD: begin
               foreach (PROT_KEY[i]) begin
                  if (!found && PROT_KEY[i] == protect_q) begin
                     r.rdata = PROT_VAL[i];
                     found   = 1'b1;
                  end
               end
            end
            default: hit = 1'b0;
         endcase
      end else if (page == PAGE_D) begin
         if (acc.addr < ADDR_CHAR_END) begin
            r.rdata = ram_mem[RGN_CHAR][acc.addr[CHAR_IDX_W-1:0]];
         end else begin
            hit = 1'b0;
         end
      end else if (page == PAGE_E) begin
         r.rdata = ram_mem[RGN_WORK][acc.addr[WORK_IDX_W-1:0]];
      end else begin
         r.rdata = ram_mem[RGN_SPRITE][acc.addr[SPR_IDX_W-1:0]];
      end
      r.unmapped     = !hit;
      r.sound_latch  = latch_q;
      r.layer_enable = layer_q;
      r.palette_bank = palbank_q;
      r.scroll_x     = scrollx_q;
      r.scroll_y     = scrolly_q;
      r.bg2_scroll   = bgscroll_q;
      r.rom_bank     = bank_q;
      return r;
   endfunction

   task automatic send_request(input bus_access_type acc);
      int gap;
      gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= acc.req_type;
      req_bus.addr        <= acc.addr;
      req_bus.wdata       <= acc.wdata;
      req_bus.in_vblank   <= acc.in_vblank;
      req_bus.system_port <= acc.system_port;
      req_bus.p1_port     <= acc.p1_port;
      req_bus.p2_port     <= acc.p2_port;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_bus_access(acc));
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dip_switch(input logic idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_DIP_A) begin
         dip_a_q = value;
      end else begin
         dip_b_q = value;
      end
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("prdata", CSR_DATA_W'(value), prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_traffic(input int count);
      int             sent;
      int             pick;
      int             idx;
      ram_region_type rgn;
      logic [DATA_W-1:0] key;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 31) == 0) req_idle = !req_idle;
         pick = $urandom_range(0, 99);
         rgn  = ram_region_type'($urandom_range(0, NUM_REGIONS - 1));
         if (pick < 10) begin
            send_request(make_access(REQ_READ, ADDR_W'($urandom_range(0, ADDR_SYS - 1)),
                                     '0));
         end else if (pick < 20) begin
            send_request(make_access(REQ_READ, PORT_READ_ADDRS[$urandom_range(0, 5)], '0));
         end else if (pick < 30) begin
            send_request(make_access(REQ_WRITE, IO_WRITE_ADDRS[$urandom_range(0, 10)],
                                     DATA_W'($urandom)));
         end else if (pick < 38) begin
            // load a protection key, then fetch its answer
            key = ($urandom_range(0, 3) != 0) ? PROT_KEY[$urandom_range(0, PROT_ENTRIES - 1)]
                                              : DATA_W'($urandom);
            send_request(make_access(REQ_WRITE, ADDR_PROT_WR, key));
            send_request(make_access(REQ_READ, ADDR_PROT_RD, '0));
            sent++;
         end else if (pick < 62 || (pick < 85 && ram_written[rgn].size() == 0)) begin
            if (rgn == RGN_SPRITE && $urandom_range(0, 3) == 0) begin
               send_request(make_access(REQ_WRITE, ADDR_MIRROR_LO
                            + ADDR_W'($urandom_range(0, (1 << MIRROR_IDX_W) - 1)),
                            DATA_W'($urandom)));
            end else begin
               idx = $urandom_range(0, (rgn == RGN_CHAR) ? CHAR_RAM_DEPTH - 1
                                                         : SPRITE_RAM_DEPTH - 1);
               send_request(make_access(REQ_WRITE, ram_address(rgn, idx), DATA_W'($urandom)));
            end
         end else if (pick < 85) begin
            idx = ram_written[rgn][$urandom_range(0, ram_written[rgn].size() - 1)];
            send_request(make_access(REQ_READ, ram_address(rgn, idx), '0));
         end else begin
            case ($urandom_range(0, 3))
               0: send_request(make_access(REQ_WRITE,
                                           ADDR_W'($urandom_range(0, ADDR_SYS - 1)),
                                           DATA_W'($urandom)));
               1: send_request(make_access(REQ_READ, {PAGE_C, 12'($urandom)}, '0));
               2: send_request(make_access(REQ_READ, {PAGE_D, 1'b1, 11'($urandom)}, '0));
               default: send_request(make_access(REQ_WRITE, {3'b110, 13'($urandom)},
                                                 DATA_W'($urandom)));
            endcase
         end
         sent++;
      end
   endtask

   task automatic test_rom_decode();
      send_request(make_access(REQ_READ, 16'h0000, '0));
      send_request(make_access(REQ_READ, 16'h8000, '0));
      send_request(make_access(REQ_WRITE, ADDR_BANK, 8'hFF));
      send_request(make_access(REQ_READ, 16'hBFFF, '0));
      send_request(make_access(REQ_WRITE, ADDR_BANK_LAYER, 8'hFF));
   endtask

   task automatic test_register_writes();
      send_request(make_access(REQ_WRITE, ADDR_LATCH, 8'hA5));
      send_request(make_access(REQ_WRITE, ADDR_PALBANK, 8'hFF));
      send_request(make_access(REQ_WRITE, ADDR_SCROLLX_HI, 8'hFF));
      send_request(make_access(REQ_WRITE, ADDR_SCROLLY, 8'hFF));
      send_request(make_access(REQ_WRITE, ADDR_BGSCROLL_HI, 8'h80));
      send_request(make_access(REQ_WRITE, ADDR_LAYER_LO, 8'hFF));
   endtask

   task automatic test_input_ports();
      bus_access_type acc;
      acc = make_access(REQ_READ, ADDR_SYS, '0);
      acc.in_vblank   = 1'b0;
      acc.system_port = 8'h00;
      send_request(acc);
      acc = make_access(REQ_READ, ADDR_SYS, '0);
      acc.in_vblank   = 1'b1;
      acc.system_port = 8'hF7;
      send_request(acc);
      send_request(make_access(REQ_READ, ADDR_DIP_A, '0));
      send_request(make_access(REQ_READ, ADDR_DIP_B, '0));
   endtask

   task automatic test_protection();
      send_request(make_access(REQ_WRITE, ADDR_PROT_WR, PROT_KEY[0]));
      send_request(make_access(REQ_READ, ADDR_PROT_RD, '0));
      send_request(make_access(REQ_WRITE, ADDR_PROT_WR, 8'h00));
      send_request(make_access(REQ_READ, ADDR_PROT_RD, '0));
   endtask

   task automatic test_ram_access();
      send_request(make_access(REQ_WRITE, ADDR_W'(ADDR_MIRROR_HI - 1), 8'h5A));
      send_request(make_access(REQ_READ, ram_address(RGN_SPRITE, (1 << MIRROR_IDX_W) - 1),
                               '0));
      send_request(make_access(REQ_WRITE, ADDR_W'(ADDR_CHAR_END - 1), 8'hC3));
      send_request(make_access(REQ_READ, ADDR_W'(ADDR_CHAR_END - 1), '0));
   endtask

   task automatic test_unmapped();
      send_request(make_access(REQ_WRITE, 16'h0000, 8'hFF));
      send_request(make_access(REQ_READ, ADDR_W'(ADDR_DIP_B + 1), '0));
      send_request(make_access(REQ_READ, ADDR_CHAR_END, '0));
   endtask

   task automatic test_dip_switches();
      drain_responses();
      write_dip_switch(CSR_DIP_A, 8'h00);
      write_dip_switch(CSR_DIP_B, 8'h80);
      send_request(make_access(REQ_READ, ADDR_DIP_A, '0));
      send_request(make_access(REQ_READ, ADDR_DIP_B, '0));
   endtask

   task automatic test_backpressure();
      drain_responses();
      req_idle = 1'b0;
      -> hold_rsp_ev;
      random_traffic(30);
      drain_responses();
      req_idle = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         case (phase)
            0: begin
               write_dip_switch(CSR_DIP_A, 8'hFF);
               write_dip_switch(CSR_DIP_B, 8'h00);
            end
            1: begin
               write_dip_switch(CSR_DIP_A, 8'h00);
               write_dip_switch(CSR_DIP_B, 8'hFF);
            end
            default: begin
               write_dip_switch(CSR_DIP_A, DATA_W'($urandom));
               write_dip_switch(CSR_DIP_B, DATA_W'($urandom));
            end
         endcase
         random_traffic(100);
      end
   endtask

   // hold the response side off for a fixed stretch
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(hold_rsp_ev);
         rsp_hold = 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   initial begin
      int wait_left;
      int taken;
      bit rsp_idle;
      wait_left     = 0;
      taken         = 0;
      rsp_idle      = 1'b1;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold || wait_left > 0) begin
            rsp_bus.ready <= 1'b0;
            if (!rsp_hold) wait_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            taken++;
            if (taken % 32 == 0) rsp_idle = ($urandom_range(0, 2) != 0);
            wait_left = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rdata: rsp_bus.rdata, rom_read: rsp_bus.rom_read,
                 rom_addr: rsp_bus.rom_addr, unmapped: rsp_bus.unmapped,
                 sound_latch: rsp_bus.sound_latch, layer_enable: rsp_bus.layer_enable,
                 palette_bank: rsp_bus.palette_bank, scroll_x: rsp_bus.scroll_x,
                 scroll_y: rsp_bus.scroll_y, bg2_scroll: rsp_bus.bg2_scroll,
                 rom_bank: rsp_bus.rom_bank};
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("rdata", want.rdata, got.rdata);
            check_field("rom_read", want.rom_read, got.rom_read);
            check_field("rom_addr", want.rom_addr, got.rom_addr);
            check_field("unmapped", want.unmapped, got.unmapped);
            check_field("sound_latch", want.sound_latch, got.sound_latch);
            check_field("layer_enable", want.layer_enable, got.layer_enable);
            check_field("palette_bank", want.palette_bank, got.palette_bank);
            check_field("scroll_x", want.scroll_x, got.scroll_x);
            check_field("scroll_y", want.scroll_y, got.scroll_y);
            check_field("bg2_scroll", want.bg2_scroll, got.bg2_scroll);
            check_field("rom_bank", want.rom_bank, got.rom_bank);
         end
      end
   end

   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_READ;
      req_bus.addr        = '0;
      req_bus.wdata       = '0;
      req_bus.in_vblank   = 1'b0;
      req_bus.system_port = '0;
      req_bus.p1_port     = '0;
      req_bus.p2_port     = '0;
      dip_a_q    = DIP_A_RESET;
      dip_b_q    = DIP_B_RESET;
      latch_q    = '0;
      palbank_q  = '0;
      protect_q  = '0;
      scrolly_q  = '0;
      bank_q     = '0;
      layer_q    = '0;
      scrollx_q  = '0;
      bgscroll_q = '0;
      req_idle   = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_rom_decode();
      test_register_writes();
      test_input_ports();
      test_protection();
      test_ram_access();
      test_unmapped();
      test_dip_switches();
      test_backpressure();
      test_random_traffic();

      drain_responses();
      if (error_count == 0) begin
         $display("main_bus_decoder_with_io_registers verification clean");
      end else begin
         $display("main_bus_decoder_with_io_registers verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/mbd_pkg.sv
design/mbd_if.sv
design/mbd_front.sv
design/mbd_queue.sv
design/mbd_back.sv
design/main_bus_decoder_with_io_registers.sv
design/mbd_checker.sv
test/tb_main_bus_decoder_with_io_registers.sv
